### hw/rtl/csvg_pkg.sv
// Package of shared types, constants and the face table for the cube-sphere vertex generator.
package csvg_pkg;

   localparam logic [6:0] MAX_GRID = 7'd64;
   localparam logic [6:0] MIN_GRID = 7'd2;

   localparam int STEP_CELLS = 18;
   localparam int SQRT_CELLS = 25;
   localparam int SCALE_CELLS = 18;
   localparam int META_DEPTH = 66;
   localparam int META_IDX = 1;
   localparam int META_VIDX = 2;
   localparam int META_COORD = 18;
   localparam int META_MAG = 20;
   localparam int META_SCALE = 46;
   localparam int META_LAST = 65;

   localparam logic [2:0] REG_RADIUS = 3'd0;
   localparam logic [2:0] REG_GRID_SIZE = 3'd1;
   localparam logic [2:0] REG_CENTER_X = 3'd2;
   localparam logic [2:0] REG_CENTER_Y = 3'd3;
   localparam logic [2:0] REG_CENTER_Z = 3'd4;

   localparam logic [2:0] LAST_FACE = 3'd5;

   typedef struct packed {
      logic [24:0] rem;
      logic [17:0] tail;
      logic [24:0] dvs;
      logic [17:0] quo;
   } div_type;

   typedef struct packed {
      logic [25:0] rem;
      logic [24:0] root;
      logic [49:0] tail;
   } sqrt_type;

   typedef struct packed {
      logic [2:0] neg;
      logic [2:0] ex;
      logic [2:0] ey;
   } face_type;

   typedef struct packed {
      logic             vld;
      logic             pv;
      logic             hq;
      logic [2:0]       face;
      logic [5:0]       row;
      logic [5:0]       col;
      logic [6:0]       n;
      logic [12:0]      nn;
      logic [12:0]      rown;
      logic [14:0]      vidx;
      logic [2:0]       neg;
      logic [2:0][32:0] mag;
   } meta_type;

   function automatic face_type face_lookup(input logic [2:0] face);
      face_type f;
      unique case (face)
         3'd1: f = '{neg: 3'b111, ex: 3'b100, ey: 3'b001};
         3'd2: f = '{neg: 3'b011, ex: 3'b001, ey: 3'b010};
         3'd3: f = '{neg: 3'b111, ex: 3'b001, ey: 3'b010};
         3'd4: f = '{neg: 3'b110, ex: 3'b100, ey: 3'b010};
         3'd5: f = '{neg: 3'b111, ex: 3'b100, ey: 3'b010};
         default: f = '{neg: 3'b101, ex: 3'b100, ey: 3'b001};
      endcase
      return f;
   endfunction

endpackage

### hw/rtl/csvg_if.sv
// Handshake interfaces for the request, response and register write channels.
interface csvg_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] face;
   logic [5:0] row;
   logic [5:0] col;
   modport source (output valid, face, row, col, input ready);
   modport sink (input valid, face, row, col, output ready);
endinterface

interface csvg_rsp_if;
   logic               valid;
   logic               ready;
   logic               point_valid;
   logic signed [23:0] x_coord;
   logic signed [23:0] y_coord;
   logic signed [23:0] z_coord;
   logic [14:0]        vertex_index;
   logic               has_quad;
   logic [14:0]        tri_a0;
   logic [14:0]        tri_a1;
   logic [14:0]        tri_a2;
   logic [14:0]        tri_b0;
   logic [14:0]        tri_b1;
   logic [14:0]        tri_b2;
   modport source (output valid, point_valid, x_coord, y_coord, z_coord, vertex_index,
                   has_quad, tri_a0, tri_a1, tri_a2, tri_b0, tri_b1, tri_b2, input ready);
   modport sink (input valid, point_valid, x_coord, y_coord, z_coord, vertex_index,
                 has_quad, tri_a0, tri_a1, tri_a2, tri_b0, tri_b1, tri_b2, output ready);
endinterface

interface csvg_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [23:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/csvg_div_cell.sv
// One restoring division cell that produces one quotient bit per cycle while en is high.
module csvg_div_cell (
   input  logic              clock,
   input  logic              en,
   input  csvg_pkg::div_type cell_in,
   output csvg_pkg::div_type cell_out
);
   csvg_pkg::div_type cell_ff;
   csvg_pkg::div_type cell_in_c;
   logic [25:0] trial;
   logic [25:0] diff;
   logic        ge;

   always_comb begin
      trial = {cell_in.rem, cell_in.tail[17]};
      diff = trial - {1'b0, cell_in.dvs};
      ge = trial >= {1'b0, cell_in.dvs};
      cell_in_c.rem = ge ? diff[24:0] : trial[24:0];
      cell_in_c.tail = {cell_in.tail[16:0], 1'b0};
      cell_in_c.dvs = cell_in.dvs;
      cell_in_c.quo = {cell_in.quo[16:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in_c;
      end
   end

   assign cell_out = cell_ff;
endmodule

### hw/rtl/csvg_sqrt_cell.sv
// One digit-by-digit square root cell that produces one root bit per cycle while en is high.
module csvg_sqrt_cell (
   input  logic               clock,
   input  logic               en,
   input  csvg_pkg::sqrt_type cell_in,
   output csvg_pkg::sqrt_type cell_out
);
   csvg_pkg::sqrt_type cell_ff;
   csvg_pkg::sqrt_type cell_in_c;
   logic [27:0] trial;
   logic [27:0] tst;
   logic [27:0] diff;
   logic        ge;

   always_comb begin
      trial = {cell_in.rem, cell_in.tail[49:48]};
      tst = {1'b0, cell_in.root, 2'b01};
      diff = trial - tst;
      ge = trial >= tst;
      cell_in_c.rem = ge ? diff[25:0] : trial[25:0];
      cell_in_c.root = {cell_in.root[23:0], ge};
      cell_in_c.tail = {cell_in.tail[47:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in_c;
      end
   end

   assign cell_out = cell_ff;
endmodule

### hw/rtl/cube_sphere_vertex_generator_core.sv
// Top level of the cube-sphere vertex generator: grid steps, length, scaling and indices.
// One request is accepted per cycle while the pipeline is not held; the cell chains are fully pipelined.
// The whole pipeline advances together and holds only while a response waits unaccepted.
// Synchronous active-high reset clears the valid bits and sets the registers to their defaults.
module cube_sphere_vertex_generator_core (
   input logic        clock,
   input logic        reset,
   csvg_req_if.sink   req,
   csvg_rsp_if.source rsp,
   csvg_csr_if.sink   csr
);
   logic [15:0]        radius_ff;
   logic [6:0]         grid_ff;
   logic signed [23:0] center_ff [3];

   logic en;
   logic [6:0] n_req;

   csvg_pkg::meta_type meta_ff [csvg_pkg::META_DEPTH];
   csvg_pkg::meta_type meta_in [csvg_pkg::META_DEPTH];

   csvg_pkg::div_type  row_chain [csvg_pkg::STEP_CELLS];
   csvg_pkg::div_type  col_chain [csvg_pkg::STEP_CELLS];
   csvg_pkg::div_type  row_init;
   csvg_pkg::div_type  col_init;
   csvg_pkg::sqrt_type sqrt_chain [csvg_pkg::SQRT_CELLS];
   csvg_pkg::sqrt_type sqrt_init;
   csvg_pkg::div_type  scale_chain [3][csvg_pkg::SCALE_CELLS];
   csvg_pkg::div_type  scale_ff [3];
   csvg_pkg::div_type  scale_in [3];

   logic signed [17:0] coord_ff [3];
   logic signed [17:0] coord_in [3];
   logic [32:0]        sq_ff [3];
   logic [33:0]        sum_ff;
   logic [5:0]         d0;
   csvg_pkg::face_type fc;

   logic               out_vld_ff;
   logic               pv_ff;
   logic               hq_ff;
   logic signed [23:0] xyz_ff [3];
   logic signed [23:0] xyz_in [3];
   logic [14:0]        vidx_ff;
   logic [14:0]        a1_ff;
   logic [14:0]        a2_ff;
   logic [14:0]        b1_ff;

   assign en = !out_vld_ff || rsp.ready;
   assign req.ready = en;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 16'd256;
         grid_ff <= 7'd2;
         center_ff[0] <= '0;
         center_ff[1] <= '0;
         center_ff[2] <= '0;
      end else if (csr.valid) begin
         unique case (csr.index)
            csvg_pkg::REG_RADIUS: radius_ff <= csr.data[15:0];
            csvg_pkg::REG_GRID_SIZE: grid_ff <= csr.data[6:0];
            csvg_pkg::REG_CENTER_X: center_ff[0] <= csr.data;
            csvg_pkg::REG_CENTER_Y: center_ff[1] <= csr.data;
            csvg_pkg::REG_CENTER_Z: center_ff[2] <= csr.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      priority if (grid_ff < csvg_pkg::MIN_GRID) begin
         n_req = csvg_pkg::MIN_GRID;
      end else if (grid_ff > csvg_pkg::MAX_GRID) begin
         n_req = csvg_pkg::MAX_GRID;
      end else begin
         n_req = grid_ff;
      end
   end

   always_comb begin
      meta_in[0] = '0;
      meta_in[0].vld = req.valid;
      meta_in[0].face = req.face;
      meta_in[0].row = req.row;
      meta_in[0].col = req.col;
      meta_in[0].n = n_req;
      meta_in[0].pv = (req.face <= csvg_pkg::LAST_FACE) && ({1'b0, req.row} < n_req)
                      && ({1'b0, req.col} < n_req);
      meta_in[0].hq = ({1'b0, req.row} < n_req - 7'd1) && ({1'b0, req.col} < n_req - 7'd1);
      for (int i = 1; i < csvg_pkg::META_DEPTH; i++) begin
         meta_in[i] = meta_ff[i-1];
      end
      meta_in[csvg_pkg::META_IDX].nn =
         13'(meta_ff[csvg_pkg::META_IDX-1].n * meta_ff[csvg_pkg::META_IDX-1].n);
      meta_in[csvg_pkg::META_IDX].rown =
         13'(meta_ff[csvg_pkg::META_IDX-1].row * meta_ff[csvg_pkg::META_IDX-1].n);
      meta_in[csvg_pkg::META_VIDX].vidx =
         15'(17'(meta_ff[csvg_pkg::META_VIDX-1].face * meta_ff[csvg_pkg::META_VIDX-1].nn)
             + 17'(meta_ff[csvg_pkg::META_VIDX-1].rown)
             + 17'(meta_ff[csvg_pkg::META_VIDX-1].col));
      for (int a = 0; a < 3; a++) begin
         meta_in[csvg_pkg::META_MAG].neg[a] = coord_ff[a][17];
         meta_in[csvg_pkg::META_MAG].mag[a] =
            33'(17'(coord_ff[a][17] ? -coord_ff[a] : coord_ff[a]) * radius_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < csvg_pkg::META_DEPTH; i++) begin
            meta_ff[i].vld <= 1'b0;
         end
      end else if (en) begin
         for (int i = 0; i < csvg_pkg::META_DEPTH; i++) begin
            meta_ff[i] <= meta_in[i];
         end
      end
   end

   always_comb begin
      d0 = 6'(meta_ff[0].n - 7'd1);
      row_init.rem = 25'(meta_ff[0].row[5:1]);
      row_init.tail = {meta_ff[0].row[0], 17'(d0[5:1])};
      row_init.dvs = 25'(d0);
      row_init.quo = '0;
      col_init.rem = 25'(meta_ff[0].col[5:1]);
      col_init.tail = {meta_ff[0].col[0], 17'(d0[5:1])};
      col_init.dvs = 25'(d0);
      col_init.quo = '0;
   end

   for (genvar g = 0; g < csvg_pkg::STEP_CELLS; g++) begin : g_step
      csvg_div_cell u_row (
         .clock    (clock),
         .en       (en),
         .cell_in  ((g == 0) ? row_init : row_chain[(g == 0) ? 0 : g-1]),
         .cell_out (row_chain[g])
      );
      csvg_div_cell u_col (
         .clock    (clock),
         .en       (en),
         .cell_in  ((g == 0) ? col_init : col_chain[(g == 0) ? 0 : g-1]),
         .cell_out (col_chain[g])
      );
   end

   always_comb begin
      fc = csvg_pkg::face_lookup(meta_ff[csvg_pkg::META_COORD].face);
      for (int a = 0; a < 3; a++) begin
         coord_in[a] = 18'((fc.neg[a] ? -19'sd65536 : 19'sd65536)
            + (fc.ey[a] ? $signed({1'b0, row_chain[csvg_pkg::STEP_CELLS-1].quo}) : 19'sd0)
            + (fc.ex[a] ? $signed({1'b0, col_chain[csvg_pkg::STEP_CELLS-1].quo}) : 19'sd0));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 3; a++) begin
            coord_ff[a] <= coord_in[a];
            sq_ff[a] <= 33'($unsigned(36'(coord_ff[a]) * 36'(coord_ff[a])));
         end
         sum_ff <= 34'(sq_ff[0]) + 34'(sq_ff[1]) + 34'(sq_ff[2]);
      end
   end

   always_comb begin
      sqrt_init.rem = '0;
      sqrt_init.root = '0;
      sqrt_init.tail = {sum_ff, 16'd0};
   end

   for (genvar g = 0; g < csvg_pkg::SQRT_CELLS; g++) begin : g_sqrt
      csvg_sqrt_cell u_sqrt (
         .clock    (clock),
         .en       (en),
         .cell_in  ((g == 0) ? sqrt_init : sqrt_chain[(g == 0) ? 0 : g-1]),
         .cell_out (sqrt_chain[g])
      );
   end

   always_comb begin
      logic [40:0] num;
      for (int a = 0; a < 3; a++) begin
         num = {meta_ff[csvg_pkg::META_SCALE].mag[a], 8'd0}
               + 41'(sqrt_chain[csvg_pkg::SQRT_CELLS-1].root[24:1]);
         scale_in[a].rem = 25'(num[40:18]);
         scale_in[a].tail = num[17:0];
         scale_in[a].dvs = sqrt_chain[csvg_pkg::SQRT_CELLS-1].root;
         scale_in[a].quo = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 3; a++) begin
            scale_ff[a] <= scale_in[a];
         end
      end
   end

   for (genvar a = 0; a < 3; a++) begin : g_axis
      for (genvar g = 0; g < csvg_pkg::SCALE_CELLS; g++) begin : g_scale
         csvg_div_cell u_scale (
            .clock    (clock),
            .en       (en),
            .cell_in  ((g == 0) ? scale_ff[a] : scale_chain[a][(g == 0) ? 0 : g-1]),
            .cell_out (scale_chain[a][g])
         );
      end
   end

   always_comb begin
      logic signed [18:0] sq;
      logic signed [24:0] tot;
      for (int a = 0; a < 3; a++) begin
         sq = $signed({1'b0, scale_chain[a][csvg_pkg::SCALE_CELLS-1].quo});
         if (meta_ff[csvg_pkg::META_LAST].neg[a]) begin
            sq = -sq;
         end
         tot = 25'(sq) + 25'(center_ff[a]);
         priority if (!meta_ff[csvg_pkg::META_LAST].pv) begin
            xyz_in[a] = '0;
         end else if (tot > 25'sd8388607) begin
            xyz_in[a] = 24'sd8388607;
         end else if (tot < -25'sd8388608) begin
            xyz_in[a] = -24'sd8388608;
         end else begin
            xyz_in[a] = 24'(tot);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= meta_ff[csvg_pkg::META_LAST].vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pv_ff <= meta_ff[csvg_pkg::META_LAST].pv;
         hq_ff <= meta_ff[csvg_pkg::META_LAST].pv && meta_ff[csvg_pkg::META_LAST].hq;
         for (int a = 0; a < 3; a++) begin
            xyz_ff[a] <= xyz_in[a];
         end
         vidx_ff <= meta_ff[csvg_pkg::META_LAST].vidx;
         a1_ff <= meta_ff[csvg_pkg::META_LAST].vidx + 15'd1;
         a2_ff <= meta_ff[csvg_pkg::META_LAST].vidx + 15'(meta_ff[csvg_pkg::META_LAST].n);
         b1_ff <= meta_ff[csvg_pkg::META_LAST].vidx + 15'(meta_ff[csvg_pkg::META_LAST].n)
                  + 15'd1;
      end
   end

   assign rsp.valid = out_vld_ff;
   assign rsp.point_valid = pv_ff;
   assign rsp.x_coord = xyz_ff[0];
   assign rsp.y_coord = xyz_ff[1];
   assign rsp.z_coord = xyz_ff[2];
   assign rsp.vertex_index = pv_ff ? vidx_ff : 15'd0;
   assign rsp.has_quad = hq_ff;
   assign rsp.tri_a0 = hq_ff ? vidx_ff : 15'd0;
   assign rsp.tri_a1 = hq_ff ? a1_ff : 15'd0;
   assign rsp.tri_a2 = hq_ff ? a2_ff : 15'd0;
   assign rsp.tri_b0 = hq_ff ? a1_ff : 15'd0;
   assign rsp.tri_b1 = hq_ff ? b1_ff : 15'd0;
   assign rsp.tri_b2 = hq_ff ? a2_ff : 15'd0;

`ifndef SYNTHESIS
   a_quad_needs_point: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.has_quad |-> rsp.point_valid)
      else $error("has_quad set without point_valid");
   a_ready_follows_out: assert property (@(posedge clock) disable iff (reset)
      req.ready == (!rsp.valid || rsp.ready))
      else $error("request ready does not follow the output register");
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp.valid)
      else $error("response valid after reset");
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.vertex_index))
      else $error("stalled response changed");
`endif
endmodule
